// ----- rtl/ccube_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccube_pkg
// Shared types and constants of the coincidence cube histogrammer.
// ----------------------------------------------------------------------------
package ccube_pkg;

    localparam int E_W   = 16;
    localparam int CNT_W = 31;
    localparam int RB_W  = 5;
    localparam int ST_W  = 2;

    localparam logic [E_W-1:0] MAX_ENERGY_RESET = 16'd4096;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [ST_W-1:0] STORE_X   = 2'd0;
    localparam logic [ST_W-1:0] STORE_XY  = 2'd1;
    localparam logic [ST_W-1:0] STORE_XYZ = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_WAIT,
        S_OUT
    } t_state;

endpackage

// ----- rtl/ccube_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccube_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ccube_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ccube_bin_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccube_bin_lane
// One binning lane: floor(e * BINS / max) by restoring division, one
// quotient bit per step.
// ----------------------------------------------------------------------------
module ccube_bin_lane
    import ccube_pkg::*;
#(
    parameter int BINS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [E_W-1:0]            i_energy,
    input  logic [E_W-1:0]            i_max,
    output logic [$clog2(BINS)-1:0]   o_bin
);

    localparam int QW = $clog2(BINS);
    localparam int PW = E_W + QW;

    logic [PW-1:0]  n_prod;
    logic [E_W:0]   n_trial;
    logic [E_W-1:0] r_rem;
    logic [QW-1:0]  r_low;
    logic [QW-1:0]  r_q;

    assign n_prod  = PW'(i_energy) * PW'(BINS);
    assign n_trial = {r_rem, r_low[QW-1]};

    // The running remainder always stays below max, so 16 bits hold it.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= n_prod[PW-1:QW];
            r_low <= n_prod[QW-1:0];
            r_q   <= '0;
        end else if (i_step) begin
            r_low <= r_low << 1;
            if (n_trial >= {1'b0, i_max}) begin
                r_rem <= E_W'(n_trial - {1'b0, i_max});
                r_q   <= QW'({r_q, 1'b1});
            end else begin
                r_rem <= n_trial[E_W-1:0];
                r_q   <= QW'({r_q, 1'b0});
            end
        end
    end

    assign o_bin = r_q;

endmodule

// ----- rtl/coincidence_cube_histogrammer_top.sv -----
`timescale 1ns / 1ps
// A fill in range is binned first: the binning lanes divide one quotient bit
// per cycle in S_DIV, then the counters are read and updated. A read or a
// dropped fill skips the division. One word is in work at a time; the next
// is taken in the cycle after the result word is loaded, which waits while the output is stalled.
// After reset the counter RAMs are swept to zero, one entry per cycle through
// every cube address, while no word is accepted.
// ----------------------------------------------------------------------------
// coincidence_cube_histogrammer_top
// Triple coincidence histogrammer with x, x-y and cube counter stores.
// ----------------------------------------------------------------------------
module coincidence_cube_histogrammer_top
    import ccube_pkg::*;
#(
    parameter int BINS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_action,
    input  logic [E_W-1:0]   i_energy_x,
    input  logic [E_W-1:0]   i_energy_y,
    input  logic [E_W-1:0]   i_energy_z,
    input  logic [ST_W-1:0]  i_which_store,
    input  logic [RB_W-1:0]  i_read_bin_x,
    input  logic [RB_W-1:0]  i_read_bin_y,
    input  logic [RB_W-1:0]  i_read_bin_z,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CNT_W-1:0] o_count,
    output logic             o_accepted,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [E_W-1:0]   i_cfg_data
);

    localparam int XW    = $clog2(BINS);
    localparam int D1    = 1 << XW;
    localparam int D2    = 1 << (2 * XW);
    localparam int D3    = 1 << (3 * XW);
    localparam int SW    = $clog2(XW + 1);

    t_state r_state, n_state;

    logic [E_W-1:0]    r_max;
    logic [3*XW-1:0]   r_clr;
    logic [SW-1:0]     r_step;
    logic              r_is_read, r_fill_ok, r_rd_ok;
    logic [ST_W-1:0]   r_store;
    logic [XW-1:0]     r_rx, r_ry, r_rz;
    logic [CNT_W-1:0]  r_count;
    logic              r_ok;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_acc;

    logic              in_acc, load, step, we, out_load;
    logic [XW-1:0]     bx, by, bz, ax, ay, az;
    logic [XW-1:0]     n_rx, n_ry, n_rz;
    logic              n_rd_ok, n_range_ok;
    logic [CNT_W-1:0]  q1, q2, q3, sel;

    assign in_acc = i_in_valid && !o_in_stall;
    assign load   = in_acc;
    assign step   = (r_state == S_DIV);

    ccube_bin_lane #(.BINS(BINS)) u_lane_x (
        .i_clk(i_clk), .i_load(load), .i_step(step),
        .i_energy(i_energy_x), .i_max(r_max), .o_bin(bx)
    );
    ccube_bin_lane #(.BINS(BINS)) u_lane_y (
        .i_clk(i_clk), .i_load(load), .i_step(step),
        .i_energy(i_energy_y), .i_max(r_max), .o_bin(by)
    );
    ccube_bin_lane #(.BINS(BINS)) u_lane_z (
        .i_clk(i_clk), .i_load(load), .i_step(step),
        .i_energy(i_energy_z), .i_max(r_max), .o_bin(bz)
    );

    // Accept-time decode of a read and the range check of a fill.
    always_comb begin
        n_rx       = XW'(i_read_bin_x);
        n_ry       = XW'(i_read_bin_y);
        n_rz       = XW'(i_read_bin_z);
        n_range_ok = (i_energy_x < r_max) && (i_energy_y < r_max)
                     && (i_energy_z < r_max);
        case (i_which_store)
            STORE_X:   n_rd_ok = (32'(i_read_bin_x) < BINS);
            STORE_XY:  n_rd_ok = (32'(i_read_bin_x) < BINS)
                                 && (32'(i_read_bin_y) < BINS);
            STORE_XYZ: n_rd_ok = (32'(i_read_bin_x) < BINS)
                                 && (32'(i_read_bin_y) < BINS)
                                 && (32'(i_read_bin_z) < BINS);
            default:   n_rd_ok = 1'b0;
        endcase
    end

    // Merge: the lanes' bins or the requested bins address all three stores.
    assign ax = r_is_read ? r_rx : bx;
    assign ay = r_is_read ? r_ry : by;
    assign az = r_is_read ? r_rz : bz;

    assign we = (r_state == S_CLEAR) || ((r_state == S_WAIT) && r_fill_ok);

    ccube_ram #(.WIDTH(CNT_W), .DEPTH(D1)) u_ram_x (
        .i_clk(i_clk), .i_we(we),
        .i_addr((r_state == S_CLEAR) ? r_clr[XW-1:0] : ax),
        .i_wdata((r_state == S_CLEAR) ? '0 : ((q1 == '1) ? q1 : q1 + 1'b1)),
        .o_rdata(q1)
    );
    ccube_ram #(.WIDTH(CNT_W), .DEPTH(D2)) u_ram_xy (
        .i_clk(i_clk), .i_we(we),
        .i_addr((r_state == S_CLEAR) ? r_clr[2*XW-1:0] : {ax, ay}),
        .i_wdata((r_state == S_CLEAR) ? '0 : ((q2 == '1) ? q2 : q2 + 1'b1)),
        .o_rdata(q2)
    );
    ccube_ram #(.WIDTH(CNT_W), .DEPTH(D3)) u_ram_xyz (
        .i_clk(i_clk), .i_we(we),
        .i_addr((r_state == S_CLEAR) ? r_clr : {az, ax, ay}),
        .i_wdata((r_state == S_CLEAR) ? '0 : ((q3 == '1) ? q3 : q3 + 1'b1)),
        .o_rdata(q3)
    );

    always_comb begin
        case (r_store)
            STORE_X:   sel = q1;
            STORE_XY:  sel = q2;
            STORE_XYZ: sel = q3;
            default:   sel = '0;
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  begin
                if (in_acc) begin
                    n_state = (i_action == ACT_FILL && n_range_ok) ? S_DIV : S_RD;
                end
            end
            S_DIV:   if (r_step == SW'(1)) n_state = S_RD;
            S_RD:    n_state = S_WAIT;
            S_WAIT:  n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_max       <= MAX_ENERGY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_read <= (i_action == ACT_READ);
            r_fill_ok <= (i_action == ACT_FILL) && n_range_ok;
            r_rd_ok   <= n_rd_ok;
            r_store   <= i_which_store;
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_rz      <= n_rz;
            r_step    <= SW'(XW);
        end else if (step) begin
            r_step <= r_step - 1'b1;
        end
        if (r_state == S_WAIT) begin
            r_count <= (r_is_read && r_rd_ok) ? sel : '0;
            r_ok    <= r_fill_ok;
        end
        if (out_load) begin
            r_out_count <= r_count;
            r_out_acc   <= r_ok;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_count     = r_out_count;
    assign o_accepted  = r_out_acc;

    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_CLEAR || r_state == S_WAIT))
        else $error("counter write outside clear or update phase");

    a_no_reclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clear sweep restarted without reset");

    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_count == '0))
        else $error("counted fill word carries a nonzero count");

    a_read_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_is_read) |-> !we)
        else $error("read word wrote a counter");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coincidence cube histogrammer. It fills energy
// triples and reads counters back, checking every result word against a
// predictor that keeps its own copy of the three counter stores.
// ----------------------------------------------------------------------------
module tb_top;
    import ccube_pkg::*;

    localparam int NBINS = 32;
    localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

    typedef struct packed {
        logic             action;
        logic [E_W-1:0]   ex;
        logic [E_W-1:0]   ey;
        logic [E_W-1:0]   ez;
        logic [ST_W-1:0]  store;
        logic [RB_W-1:0]  rx;
        logic [RB_W-1:0]  ry;
        logic [RB_W-1:0]  rz;
    } t_word;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             accepted;
    } t_result;

    // One directed row: the word, and optionally a result typed in by hand.
    typedef struct packed {
        t_word   w;
        logic    fixed;
        t_result res;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_action = 1'b0;
    logic [E_W-1:0]   i_energy_x = '0;
    logic [E_W-1:0]   i_energy_y = '0;
    logic [E_W-1:0]   i_energy_z = '0;
    logic [ST_W-1:0]  i_which_store = '0;
    logic [RB_W-1:0]  i_read_bin_x = '0;
    logic [RB_W-1:0]  i_read_bin_y = '0;
    logic [RB_W-1:0]  i_read_bin_z = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [CNT_W-1:0] o_count;
    logic             o_accepted;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [E_W-1:0]   i_cfg_data = '0;

    coincidence_cube_histogrammer_top #(.BINS(NBINS)) DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state.
    logic [E_W-1:0]   lim_energy;
    logic [CNT_W-1:0] x_cnt [NBINS];
    logic [CNT_W-1:0] xy_cnt [NBINS*NBINS];
    logic [CNT_W-1:0] cube_cnt [NBINS*NBINS*NBINS];

    t_result pending_results [$];
    int      error_count = 0;
    int      fills_counted = 0;
    int      reads_done = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_recv = 1'b0;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == CNT_FULL) ? c : c + 1'b1;
    endfunction

    function automatic int bin_of(logic [E_W-1:0] e);
        return int'((longint'(e) * NBINS) / longint'(lim_energy));
    endfunction

    function automatic t_result histogram_step(t_word w);
        t_result r;
        int bx, by, bz;
        r = '0;
        if (w.action == ACT_FILL) begin
            if (w.ex < lim_energy && w.ey < lim_energy && w.ez < lim_energy) begin
                bx = bin_of(w.ex);
                by = bin_of(w.ey);
                bz = bin_of(w.ez);
                x_cnt[bx] = bump(x_cnt[bx]);
                xy_cnt[bx*NBINS+by] = bump(xy_cnt[bx*NBINS+by]);
                cube_cnt[(bz*NBINS+bx)*NBINS+by] = bump(cube_cnt[(bz*NBINS+bx)*NBINS+by]);
                r.accepted = 1'b1;
                fills_counted++;
            end
        end else begin
            reads_done++;
            case (w.store)
                STORE_X:   r.count = x_cnt[w.rx];
                STORE_XY:  r.count = xy_cnt[w.rx*NBINS+w.ry];
                STORE_XYZ: r.count = cube_cnt[(w.rz*NBINS+w.rx)*NBINS+w.ry];
                default:   r.count = '0;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    // Receiver: stall pattern and result checking.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", o_count, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_count !== want.count)
                    report_mismatch("count", o_count, want.count);
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", o_accepted, want.accepted);
            end
        end
        i_out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end

    // Valid stays high after a word is taken until the next word or a pause
    // replaces it, so each edge sees at most one assignment to it.
    task automatic send_word(t_word w, bit fixed, t_result res);
        t_result p;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= w.action;
        i_energy_x    <= w.ex;
        i_energy_y    <= w.ey;
        i_energy_z    <= w.ez;
        i_which_store <= w.store;
        i_read_bin_x  <= w.rx;
        i_read_bin_y  <= w.ry;
        i_read_bin_z  <= w.rz;
        do @(posedge i_clk); while (o_in_stall);
        p = histogram_step(w);
        if (fixed && p !== res)
            report_mismatch("predictor vs table", p, res);
        pending_results.push_back(p);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [E_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lim_energy = v;
    endtask

    function automatic t_word rand_word(bit focus);
        t_word w;
        int hi;
        w.action = ($urandom_range(99) < 55) ? ACT_FILL : ACT_READ;
        hi = (lim_energy == 0) ? 0 : int'(lim_energy) - 1;
        if (focus && $urandom_range(9) != 0) begin
            // Mostly in-range energies, x and z clustered low so counters build up.
            w.ex = E_W'($urandom_range(hi < 64 ? hi : 64));
            w.ey = E_W'($urandom_range(hi));
            w.ez = E_W'($urandom_range(hi < 64 ? hi : 64));
        end else begin
            w.ex = E_W'($urandom);
            w.ey = E_W'($urandom);
            w.ez = E_W'($urandom);
        end
        w.store = ST_W'($urandom);
        w.rx = RB_W'(($urandom_range(3) != 0) ? $urandom_range(2) : $urandom);
        w.ry = RB_W'($urandom);
        w.rz = RB_W'(($urandom_range(3) != 0) ? $urandom_range(2) : $urandom);
        return w;
    endfunction

    function automatic t_word fill(int x, int y, int z);
        t_word w;
        w = '0;
        w.action = ACT_FILL;
        w.ex = E_W'(x);
        w.ey = E_W'(y);
        w.ez = E_W'(z);
        return w;
    endfunction

    function automatic t_word rd(logic [ST_W-1:0] s, int x, int y, int z);
        t_word w;
        w = '0;
        w.action = ACT_READ;
        w.store = s;
        w.rx = RB_W'(x);
        w.ry = RB_W'(y);
        w.rz = RB_W'(z);
        return w;
    endfunction

    function automatic t_result res(int c, bit a);
        t_result r;
        r.count = CNT_W'(c);
        r.accepted = a;
        return r;
    endfunction

    initial begin
        t_row table_rows [$];
        t_result none;
        int phase;
        none = '0;
        lim_energy = MAX_ENERGY_RESET;
        foreach (x_cnt[i]) x_cnt[i] = '0;
        foreach (xy_cnt[i]) xy_cnt[i] = '0;
        foreach (cube_cnt[i]) cube_cnt[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset limit of 4096.
        table_rows.push_back('{rd(STORE_X, 0, 0, 0), 1'b1, res(0, 0)});
        table_rows.push_back('{rd(STORE_XYZ, 31, 31, 31), 1'b1, res(0, 0)});
        table_rows.push_back('{fill(0, 0, 0), 1'b1, res(0, 1)});
        table_rows.push_back('{fill(4095, 4095, 4095), 1'b1, res(0, 1)});
        table_rows.push_back('{fill(4096, 0, 0), 1'b1, res(0, 0)});
        table_rows.push_back('{fill(0, 4096, 0), 1'b1, res(0, 0)});
        table_rows.push_back('{fill(0, 0, 65535), 1'b1, res(0, 0)});
        table_rows.push_back('{fill(65535, 65535, 65535), 1'b1, res(0, 0)});
        table_rows.push_back('{fill(127, 128, 4000), 1'b0, none});
        table_rows.push_back('{rd(STORE_X, 0, 0, 0), 1'b1, res(2, 0)});
        table_rows.push_back('{rd(STORE_XY, 0, 0, 0), 1'b1, res(1, 0)});
        table_rows.push_back('{rd(STORE_XYZ, 0, 0, 0), 1'b1, res(1, 0)});
        table_rows.push_back('{rd(STORE_XYZ, 31, 31, 31), 1'b1, res(1, 0)});
        table_rows.push_back('{rd(STORE_XY, 0, 1, 0), 1'b0, none});
        table_rows.push_back('{rd(STORE_XYZ, 0, 1, 31), 1'b0, none});
        table_rows.push_back('{rd(2'd3, 0, 0, 0), 1'b1, res(0, 0)});
        table_rows.push_back('{rd(2'd3, 31, 31, 31), 1'b1, res(0, 0)});
        foreach (table_rows[i])
            send_word(table_rows[i].w, table_rows[i].fixed, table_rows[i].res);

        // Smallest nonzero limit, then the largest, then zero.
        write_limit(16'd1);
        send_word(fill(0, 0, 0), 1'b1, res(0, 1));
        send_word(fill(1, 0, 0), 1'b1, res(0, 0));
        write_limit(16'hFFFF);
        send_word(fill(65534, 0, 2047), 1'b0, none);
        send_word(fill(65535, 0, 0), 1'b1, res(0, 0));
        write_limit(16'd0);
        send_word(fill(0, 0, 0), 1'b1, res(0, 0));

        // Random phases over several limits and idling mixes.
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_limit(16'd4096);
                1: write_limit(16'd33);
                2: write_limit(E_W'($urandom_range(65535, 1)));
                3: write_limit(16'hFFFF);
                4: write_limit(16'd0);
                5: write_limit(16'd100);
                6: write_limit(E_W'($urandom_range(2000, 1)));
                default: write_limit(16'd1);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (phase == 2) begin
                // Long receiver hold-off while the sender keeps offering words.
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            repeat (190) send_word(rand_word(phase != 4), 1'b0, none);
            if (phase == 5) begin
                // Sender pauses until every result is in, then goes on.
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                repeat (10) send_word(rand_word(1'b1), 1'b0, none);
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        $display("Covered %0d counted fills and %0d reads over eight limit settings,",
                 fills_counted, reads_done);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- coincidence_cube_histogrammer_top.f -----
rtl/ccube_pkg.sv
rtl/ccube_ram.sv
rtl/ccube_bin_lane.sv
rtl/coincidence_cube_histogrammer_top.sv
tb/tb_top.sv
